FILE: hw/rtl/nv12rgb_pkg.sv
// Shared types and constants for the NV12 to RGB conversion pipeline.
// No dependencies; imported by every module of the block.
package nv12rgb_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH    = 2'd0,
        CFG_FRAME_HEIGHT   = 2'd1,
        CFG_COLOR_STANDARD = 2'd2,
        CFG_UNUSED         = 2'd3
    } cfg_index_t;

    localparam int CFG_DATA_W = 13;
    localparam int OFFSET_W   = 26;

    localparam int FRAME_WIDTH_RESET  = 1920;
    localparam int FRAME_HEIGHT_RESET = 1080;

    // Matrix coefficients, scaled by 2^16
    localparam logic signed [18:0] LUMA_GAIN   = 19'sd76309;
    localparam logic signed [18:0] BT601_CVR   = 19'sd104597;
    localparam logic signed [18:0] BT601_CUG   = 19'sd25675;
    localparam logic signed [18:0] BT601_CVG   = 19'sd53281;
    localparam logic signed [18:0] BT601_CUB   = 19'sd132201;
    localparam logic signed [18:0] BT709_CVR   = 19'sd117489;
    localparam logic signed [18:0] BT709_CUG   = 19'sd13975;
    localparam logic signed [18:0] BT709_CVG   = 19'sd34925;
    localparam logic signed [18:0] BT709_CUB   = 19'sd138443;

    localparam logic signed [8:0] LUMA_BLACK   = 9'sd16;
    localparam logic signed [8:0] CHROMA_ZERO  = 9'sd128;

    // Item handed from the chroma front end to the matrix stages
    typedef struct packed {
        logic [7:0]          luma;
        logic [7:0]          u_val;
        logic [7:0]          v_val;
        logic [OFFSET_W-1:0] offset;
    } conv_item_t;

    // Pipeline handshake between modules
    typedef struct packed {
        logic       valid;
        conv_item_t item;
    } conv_link_t;

endpackage

FILE: hw/rtl/nv12rgb_front.sv
// Front end: bounds check, bilinear chroma interpolation and output offset.
// Two register stages; depends on nv12rgb_pkg.
module nv12rgb_front
    import nv12rgb_pkg::*;
#(
    parameter int FW_W = 13
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [FW_W-1:0]     frame_width,
    input  logic [FW_W-1:0]     frame_height,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [11:0]         pixel_column,
    input  logic [11:0]         pixel_row,
    input  logic [7:0]          luma,
    input  logic [7:0]          u_top_left,
    input  logic [7:0]          v_top_left,
    input  logic [7:0]          u_top_right,
    input  logic [7:0]          v_top_right,
    input  logic [7:0]          u_bottom_left,
    input  logic [7:0]          v_bottom_left,
    input  logic [7:0]          u_bottom_right,
    input  logic [7:0]          v_bottom_right,
    output conv_link_t          down,
    input  logic                down_ready
);

    localparam int PROD_W = 12 + FW_W;

    // Weights 3/4 and 1/4 on a scale of 2048 reduce exactly to (3*near + far) >> 2
    function automatic logic [7:0] lerp_pair(input logic [7:0] a, input logic [7:0] b,
                                             input logic odd);
        logic [7:0] near;
        logic [7:0] far;
        logic [9:0] sum;
        begin
            near = odd ? a : b;
            far  = odd ? b : a;
            sum  = {1'b0, near, 1'b0} + {2'b00, near} + {2'b00, far};
            return sum[9:2];
        end
    endfunction

    logic              s1_valid_reg;
    logic [7:0]        s1_luma_reg;
    logic [7:0]        s1_u_top_reg;
    logic [7:0]        s1_v_top_reg;
    logic [7:0]        s1_u_bot_reg;
    logic [7:0]        s1_v_bot_reg;
    logic              s1_y_odd_reg;
    logic [11:0]       s1_column_reg;
    logic [PROD_W-1:0] s1_prod_reg;

    logic              s2_valid_reg;
    conv_item_t        s2_item_reg;

    logic              s1_en;
    logic              s2_en;
    logic              in_frame;
    logic [OFFSET_W-1:0] off_base;
    conv_item_t        s2_item_next;

    assign s2_en    = !s2_valid_reg || down_ready;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign in_ready = s1_en;

    assign in_frame = (32'(pixel_column) < 32'(frame_width)) &&
                      (32'(pixel_row) < 32'(frame_height));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
            begin
                // drop pixels outside the frame here
                s1_valid_reg <= in_valid && in_frame;
            end
            if (s2_en)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            s1_luma_reg   <= luma;
            s1_u_top_reg  <= lerp_pair(u_top_left, u_top_right, pixel_column[0]);
            s1_v_top_reg  <= lerp_pair(v_top_left, v_top_right, pixel_column[0]);
            s1_u_bot_reg  <= lerp_pair(u_bottom_left, u_bottom_right, pixel_column[0]);
            s1_v_bot_reg  <= lerp_pair(v_bottom_left, v_bottom_right, pixel_column[0]);
            s1_y_odd_reg  <= pixel_row[0];
            s1_column_reg <= pixel_column;
            s1_prod_reg   <= PROD_W'(pixel_row) * PROD_W'(frame_width);
        end
        if (s2_en)
        begin
            s2_item_reg <= s2_item_next;
        end
    end

    always_comb
    begin
        off_base            = OFFSET_W'(s1_prod_reg) + OFFSET_W'(s1_column_reg);
        s2_item_next.luma   = s1_luma_reg;
        s2_item_next.u_val  = lerp_pair(s1_u_top_reg, s1_u_bot_reg, s1_y_odd_reg);
        s2_item_next.v_val  = lerp_pair(s1_v_top_reg, s1_v_bot_reg, s1_y_odd_reg);
        s2_item_next.offset = {off_base[OFFSET_W-2:0], 1'b0} + off_base;
    end

    assign down.valid = s2_valid_reg;
    assign down.item  = s2_item_reg;

endmodule

FILE: hw/rtl/nv12rgb_matrix.sv
// Color matrix: products, sums, floor shift, clamp and the output register.
// Two register stages; depends on nv12rgb_pkg.
module nv12rgb_matrix
    import nv12rgb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                color_standard,
    input  conv_link_t          up,
    output logic                up_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          red,
    output logic [7:0]          green,
    output logic [7:0]          blue,
    output logic [OFFSET_W-1:0] output_offset
);

    function automatic logic [7:0] clamp_byte(input logic signed [27:0] sum);
        logic signed [11:0] sh;
        begin
            sh = sum[27:16];
            if (sh[11])
            begin
                return 8'd0;
            end
            else if (|sh[10:8])
            begin
                return 8'd255;
            end
            else
            begin
                return sh[7:0];
            end
        end
    endfunction

    logic                  s3_valid_reg;
    logic signed [27:0]    s3_yterm_reg;
    logic signed [27:0]    s3_vr_reg;
    logic signed [27:0]    s3_ug_reg;
    logic signed [27:0]    s3_vg_reg;
    logic signed [27:0]    s3_ub_reg;
    logic [OFFSET_W-1:0]   s3_offset_reg;

    logic                  out_valid_reg;
    logic [7:0]            red_reg;
    logic [7:0]            green_reg;
    logic [7:0]            blue_reg;
    logic [OFFSET_W-1:0]   offset_reg;

    logic                  s3_en;
    logic                  out_en;
    logic signed [8:0]     luma_d;
    logic signed [8:0]     u_d;
    logic signed [8:0]     v_d;
    logic signed [18:0]    cvr;
    logic signed [18:0]    cug;
    logic signed [18:0]    cvg;
    logic signed [18:0]    cub;

    assign out_en   = !out_valid_reg || out_ready;
    assign s3_en    = !s3_valid_reg || out_en;
    assign up_ready = s3_en;

    always_comb
    begin
        luma_d = $signed({1'b0, up.item.luma}) - LUMA_BLACK;
        u_d    = $signed({1'b0, up.item.u_val}) - CHROMA_ZERO;
        v_d    = $signed({1'b0, up.item.v_val}) - CHROMA_ZERO;
        if (color_standard)
        begin
            cvr = BT709_CVR;
            cug = BT709_CUG;
            cvg = BT709_CVG;
            cub = BT709_CUB;
        end
        else
        begin
            cvr = BT601_CVR;
            cug = BT601_CUG;
            cvg = BT601_CVG;
            cub = BT601_CUB;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s3_en)
            begin
                s3_valid_reg <= up.valid;
            end
            if (out_en)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_en)
        begin
            s3_yterm_reg  <= 28'(luma_d) * 28'(LUMA_GAIN);
            s3_vr_reg     <= 28'(v_d) * 28'(cvr);
            s3_ug_reg     <= 28'(u_d) * 28'(cug);
            s3_vg_reg     <= 28'(v_d) * 28'(cvg);
            s3_ub_reg     <= 28'(u_d) * 28'(cub);
            s3_offset_reg <= up.item.offset;
        end
        if (out_en)
        begin
            red_reg    <= clamp_byte(s3_yterm_reg + s3_vr_reg);
            green_reg  <= clamp_byte(s3_yterm_reg - s3_ug_reg - s3_vg_reg);
            blue_reg   <= clamp_byte(s3_yterm_reg + s3_ub_reg);
            offset_reg <= s3_offset_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign red           = red_reg;
    assign green         = green_reg;
    assign blue          = blue_reg;
    assign output_offset = offset_reg;

endmodule

FILE: hw/rtl/nv12_to_rgb_bilinear_chroma_unit.sv
// Top level of the NV12 to RGB converter with bilinear chroma.
// Holds the configuration registers; uses nv12rgb_pkg, nv12rgb_front, nv12rgb_matrix.
//
// One pixel per clock goes in, one RGB result per clock comes out, while the
// output is ready. Each pixel carries its column, row, luma byte and the four
// chroma U/V pairs that the feeder has already fetched at the edge-clamped
// chroma positions. The block interpolates U and V bilinearly (3/4 and 1/4
// weights by pixel parity), applies the BT.601 or BT.709 matrix, clamps to
// 0..255 and gives the byte offset (row*frame_width + column)*3 of the packed
// output. A result passes through four register stages: bounds check and
// horizontal chroma pass with the row*width multiply, vertical chroma pass
// with the offset sum, the five matrix multiplies, and the sums with clamp
// into the output register. A stalled output holds only the stages behind it
// that are full, so bubbles in the pipeline still take new items. Pixels
// outside the configured frame are accepted and dropped, giving no result.
// Configuration registers are written through a plain write port and should
// change only while the pipeline is empty; frame sizes above MAX_WIDTH or
// MAX_HEIGHT saturate at those limits.
module nv12_to_rgb_bilinear_chroma_unit
    import nv12rgb_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // pixel input channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [11:0]           pixel_column,
    input  logic [11:0]           pixel_row,
    input  logic [7:0]            luma,
    input  logic [7:0]            u_top_left,
    input  logic [7:0]            v_top_left,
    input  logic [7:0]            u_top_right,
    input  logic [7:0]            v_top_right,
    input  logic [7:0]            u_bottom_left,
    input  logic [7:0]            v_bottom_left,
    input  logic [7:0]            u_bottom_right,
    input  logic [7:0]            v_bottom_right,
    // result channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            red,
    output logic [7:0]            green,
    output logic [7:0]            blue,
    output logic [OFFSET_W-1:0]   output_offset
);

    // Frame size registers are just wide enough to hold the limit itself
    localparam int FW_W = $clog2(MAX_WIDTH + 1);
    localparam int FH_W = $clog2(MAX_HEIGHT + 1);
    localparam int FS_W = (FW_W > FH_W) ? FW_W : FH_W;
    localparam int WIDTH_RESET  =
        (FRAME_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RESET;
    localparam int HEIGHT_RESET =
        (FRAME_HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RESET;

    logic [FW_W-1:0] frame_width_reg;
    logic [FH_W-1:0] frame_height_reg;
    logic            color_standard_reg;
    logic [FW_W-1:0] frame_width_next;
    logic [FH_W-1:0] frame_height_next;
    logic            color_standard_next;

    conv_link_t      front_link;
    logic            front_ready;

    // Register writes: saturate frame sizes, ignore unknown indexes
    always_comb
    begin
        frame_width_next    = frame_width_reg;
        frame_height_next   = frame_height_reg;
        color_standard_next = color_standard_reg;
        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_FRAME_WIDTH:
                begin
                    frame_width_next = (int'(cfg_data) > MAX_WIDTH) ?
                                       FW_W'(MAX_WIDTH) : FW_W'(cfg_data);
                end
                CFG_FRAME_HEIGHT:
                begin
                    frame_height_next = (int'(cfg_data) > MAX_HEIGHT) ?
                                        FH_W'(MAX_HEIGHT) : FH_W'(cfg_data);
                end
                CFG_COLOR_STANDARD:
                begin
                    color_standard_next = cfg_data[0];
                end
                default:
                begin
                    // unknown register: hold everything
                    frame_width_next = frame_width_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg    <= FW_W'(WIDTH_RESET);
            frame_height_reg   <= FH_W'(HEIGHT_RESET);
            color_standard_reg <= 1'b1;
        end
        else
        begin
            frame_width_reg    <= frame_width_next;
            frame_height_reg   <= frame_height_next;
            color_standard_reg <= color_standard_next;
        end
    end

    // Stages 1 and 2: bounds check, chroma interpolation, output offset
    nv12rgb_front #(
        .FW_W (FS_W)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .frame_width    (FS_W'(frame_width_reg)),
        .frame_height   (FS_W'(frame_height_reg)),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .pixel_column   (pixel_column),
        .pixel_row      (pixel_row),
        .luma           (luma),
        .u_top_left     (u_top_left),
        .v_top_left     (v_top_left),
        .u_top_right    (u_top_right),
        .v_top_right    (v_top_right),
        .u_bottom_left  (u_bottom_left),
        .v_bottom_left  (v_bottom_left),
        .u_bottom_right (u_bottom_right),
        .v_bottom_right (v_bottom_right),
        .down           (front_link),
        .down_ready     (front_ready)
    );

    // Stages 3 and 4: matrix products, sums, clamp, output register
    nv12rgb_matrix u_matrix (
        .clk            (clk),
        .rst_n          (rst_n),
        .color_standard (color_standard_reg),
        .up             (front_link),
        .up_ready       (front_ready),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .output_offset  (output_offset)
    );

    // Input back-pressure only ever comes from a stalled, full output
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled while output is free");

    // A frame size write never leaves the register above its limit
    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT)) |=>
        (int'(frame_width_reg) <= MAX_WIDTH && int'(frame_height_reg) <= MAX_HEIGHT))
        else $error("frame size register above its limit");

    // A stalled output holds the front end's last stage back from the matrix
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready && front_link.valid && !front_ready) |=>
        (out_valid && front_link.valid))
        else $error("item lost in a stalled pipeline");

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for nv12_to_rgb_bilinear_chroma_unit.
// Checks each RGB pixel against a predictor; depends on nv12rgb_pkg and the unit RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import nv12rgb_pkg::*;

    // Frame size limits of the instance and the chroma weights on a 2048 scale
    localparam int MAX_W       = 4096;
    localparam int MAX_H       = 4096;
    localparam int W_FULL      = 2048;
    localparam int W_NEAR_EVEN = 1536;
    localparam int W_NEAR_ODD  = 512;
    localparam int LONG_HOLD   = 80;

    // Matrix coefficients, 2^16 scale
    localparam int K_LUMA   = 76309;
    localparam int K601_CVR = 104597;
    localparam int K601_CUG = 25675;
    localparam int K601_CVG = 53281;
    localparam int K601_CUB = 132201;
    localparam int K709_CVR = 117489;
    localparam int K709_CUG = 13975;
    localparam int K709_CVG = 34925;
    localparam int K709_CUB = 138443;

    // Color standard values of the select register
    localparam logic STD_BT601 = 1'b0;
    localparam logic STD_BT709 = 1'b1;

    // One pixel as the feeder hands it over. Corner order of the chroma
    // bytes: 0 top left, 1 top right, 2 bottom left, 3 bottom right.
    typedef struct packed {
        logic [11:0]      col;
        logic [11:0]      row;
        logic [7:0]       luma;
        logic [3:0][7:0]  u;
        logic [3:0][7:0]  v;
    } pixel_t;

    typedef struct packed {
        logic [7:0]          red;
        logic [7:0]          green;
        logic [7:0]          blue;
        logic [OFFSET_W-1:0] offset;
    } rgb_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    cfg_index_t            cfg_index = CFG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    pixel_t                drv_pix = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic [OFFSET_W-1:0]   output_offset;

    // Predictor copy of the configuration registers, starting at reset values
    int   frame_w    = 1920;
    int   frame_h    = 1080;
    logic matrix_sel = STD_BT709;

    pixel_t pixel_q[$];       // pixels waiting to be offered to the unit
    rgb_t   rgb_expect_q[$];  // predicted RGB results, oldest first

    logic pix_taken = 1'b0;   // item on the input bus was accepted at the last rising edge
    int   gap_left = 0;
    int   stall_left = 0;
    bit   idle_on = 1'b1;
    bit   hold_req = 1'b0;
    int   hold_cnt = 0;
    int   fail_cnt = 0;

    nv12_to_rgb_bilinear_chroma_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .pixel_column   (drv_pix.col),
        .pixel_row      (drv_pix.row),
        .luma           (drv_pix.luma),
        .u_top_left     (drv_pix.u[0]),
        .v_top_left     (drv_pix.v[0]),
        .u_top_right    (drv_pix.u[1]),
        .v_top_right    (drv_pix.v[1]),
        .u_bottom_left  (drv_pix.u[2]),
        .v_bottom_left  (drv_pix.v[2]),
        .u_bottom_right (drv_pix.u[3]),
        .v_bottom_right (drv_pix.v[3]),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .output_offset  (output_offset)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Weighted mix of two chroma bytes, truncated back to the byte scale
    function automatic int chroma_mix(input int a, input int b, input int w);
        return (a * (W_FULL - w) + b * w) >> 11;
    endfunction

    // Floor shift by 16 and clamp to one byte
    function automatic logic [7:0] clamp_channel(input int acc);
        int s;
        s = acc >>> 16;
        if (s < 0)
            return 8'd0;
        if (s > 255)
            return 8'd255;
        return s[7:0];
    endfunction

    // Compute the RGB result of one pixel; return 0 when the pixel lies
    // outside the configured frame and no result is due.
    function automatic bit convert_pixel(input pixel_t p, output rgb_t res);
        int     wx, wy, u_i, v_i, y_term, u_d, v_d;
        int     cvr, cug, cvg, cub;
        longint pos;
        res = '0;
        if (p.col >= frame_w || p.row >= frame_h)
            return 1'b0;
        if (matrix_sel == STD_BT601)
        begin
            cvr = K601_CVR;
            cug = K601_CUG;
            cvg = K601_CVG;
            cub = K601_CUB;
        end
        else
        begin
            cvr = K709_CVR;
            cug = K709_CUG;
            cvg = K709_CVG;
            cub = K709_CUB;
        end
        // Odd coordinates sit nearer the first chroma sample
        wx = p.col[0] ? W_NEAR_ODD : W_NEAR_EVEN;
        wy = p.row[0] ? W_NEAR_ODD : W_NEAR_EVEN;
        // Horizontal pass on both rows, then the vertical pass
        u_i = chroma_mix(chroma_mix(p.u[0], p.u[1], wx), chroma_mix(p.u[2], p.u[3], wx), wy);
        v_i = chroma_mix(chroma_mix(p.v[0], p.v[1], wx), chroma_mix(p.v[2], p.v[3], wx), wy);
        y_term = (int'(p.luma) - 16) * K_LUMA;
        u_d = u_i - 128;
        v_d = v_i - 128;
        res.red   = clamp_channel(y_term + v_d * cvr);
        res.green = clamp_channel(y_term - u_d * cug - v_d * cvg);
        res.blue  = clamp_channel(y_term + u_d * cub);
        // Packed RGB byte offset, wrapped to the port width
        pos = (longint'(p.row) * frame_w + longint'(p.col)) * 3;
        res.offset = pos[OFFSET_W-1:0];
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Input driver: change the bus at the falling edge only
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        // Hold the current item until it has been taken
        if (!in_valid || pix_taken)
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (idle_on && pixel_q.size() != 0 && $urandom_range(0, 7) == 0)
            begin
                // Start a sender gap of random length
                in_valid <= 1'b0;
                gap_left <= $urandom_range(0, 3);
            end
            else if (pixel_q.size() != 0)
            begin
                drv_pix  <= pixel_q.pop_front();
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output receiver: one long hold-off on request, short random stalls
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_req && hold_cnt < LONG_HOLD)
        begin
            // Keep the output blocked so the pipeline fills and stops taking pixels
            out_ready <= 1'b0;
            hold_cnt  <= hold_cnt + 1;
        end
        else if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict accepted pixels and check results, at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        rgb_t want;
        rgb_t got;
        pix_taken <= in_valid && in_ready;
        if (rst_n)
        begin
            if (in_valid && in_ready && convert_pixel(drv_pix, want))
                rgb_expect_q.push_back(want);
            if (out_valid && out_ready)
            begin
                got = '{red: red, green: green, blue: blue, offset: output_offset};
                if (rgb_expect_q.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("%0t: unexpected result r=%0d g=%0d b=%0d offset=%0d",
                                 $realtime, got.red, got.green, got.blue, got.offset);
                end
                else
                begin
                    want = rgb_expect_q.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue || got.offset !== want.offset)
                    begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display({"%0t: result mismatch: expected r=%0d g=%0d b=%0d ",
                                      "offset=%0d, got r=%0d g=%0d b=%0d offset=%0d"},
                                     $realtime, want.red, want.green, want.blue,
                                     want.offset, got.red, got.green, got.blue, got.offset);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Return once every pixel is sent and every result has come, then let
    // dropped pixels drain from the four pipeline stages. Checked at the
    // rising edge, where the queues and the input bus are stable.
    task automatic wait_idle();
        @(posedge clk);
        while (pixel_q.size() != 0 || in_valid || rgb_expect_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Write one register while the pipeline is empty and track it in the predictor
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        wait_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_FRAME_WIDTH:    frame_w = (val > MAX_W) ? MAX_W : int'(val);
            CFG_FRAME_HEIGHT:   frame_h = (val > MAX_H) ? MAX_H : int'(val);
            CFG_COLOR_STANDARD: matrix_sel = val[0];
            default:            ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_frame(input int w, input int h, input logic std);
        write_reg(CFG_FRAME_WIDTH, w[CFG_DATA_W-1:0]);
        write_reg(CFG_FRAME_HEIGHT, h[CFG_DATA_W-1:0]);
        write_reg(CFG_COLOR_STANDARD, {{(CFG_DATA_W-1){1'b0}}, std});
    endtask

    task automatic push_pixel(input logic [11:0] c, input logic [11:0] r,
                              input logic [7:0] y, input logic [31:0] u,
                              input logic [31:0] v);
        pixel_t p;
        p.col  = c;
        p.row  = r;
        p.luma = y;
        p.u    = u;
        p.v    = v;
        pixel_q.push_back(p);
    endtask

    // Random byte, biased toward the extremes so that clamping is reached
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly pixels inside the current frame, some anywhere in the field range
    function automatic pixel_t rand_pixel();
        pixel_t p;
        if ($urandom_range(0, 9) < 8 && frame_w > 0 && frame_h > 0)
        begin
            p.col = 12'($urandom_range(0, frame_w - 1));
            p.row = 12'($urandom_range(0, frame_h - 1));
        end
        else
        begin
            p.col = 12'($urandom_range(0, 4095));
            p.row = 12'($urandom_range(0, 4095));
        end
        p.luma = rand_byte();
        for (int i = 0; i < 4; i++)
        begin
            p.u[i] = rand_byte();
            p.v[i] = rand_byte();
        end
        return p;
    endfunction

    task automatic push_random(input int count);
        for (int i = 0; i < count; i++)
            pixel_q.push_back(rand_pixel());
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Directed part, first with the reset configuration (1920x1080, BT.709)
        push_pixel(12'd0, 12'd0, 8'd0, 32'h0000_0000, 32'h0000_0000);
        push_pixel(12'd1919, 12'd1079, 8'd255, 32'hffff_ffff, 32'hffff_ffff);
        push_pixel(12'd1, 12'd0, 8'd128, 32'h10_60_a0_f0, 32'hf0_a0_60_10);
        push_pixel(12'd0, 12'd1, 8'd128, 32'h10_60_a0_f0, 32'hf0_a0_60_10);
        push_pixel(12'd1, 12'd1, 8'd128, 32'h10_60_a0_f0, 32'hf0_a0_60_10);
        push_pixel(12'd2, 12'd2, 8'd16, 32'h8080_8080, 32'h8080_8080);
        // Just outside the frame on each side, and the far corner of the field
        push_pixel(12'd1920, 12'd5, 8'd100, 32'h1234_5678, 32'h9abc_def0);
        push_pixel(12'd5, 12'd1080, 8'd100, 32'h1234_5678, 32'h9abc_def0);
        push_pixel(12'd4095, 12'd4095, 8'd100, 32'h1234_5678, 32'h9abc_def0);

        // BT.601 matrix
        write_reg(CFG_COLOR_STANDARD, CFG_DATA_W'(STD_BT601));
        push_pixel(12'd3, 12'd3, 8'd235, 32'hff00_ff00, 32'h00ff_00ff);
        push_pixel(12'd10, 12'd7, 8'd81, 32'h00ff_00ff, 32'hff00_ff00);

        // A write to the unused index must leave every register alone
        write_reg(CFG_UNUSED, 13'h1fff);
        push_pixel(12'd1919, 12'd1079, 8'd200, 32'h2040_6080, 32'h80a0_c0e0);
        push_pixel(12'd1920, 12'd0, 8'd200, 32'h2040_6080, 32'h80a0_c0e0);

        // Oversized frame sizes saturate at the limits
        write_reg(CFG_FRAME_WIDTH, 13'd8191);
        write_reg(CFG_FRAME_HEIGHT, 13'd4097);
        push_pixel(12'd4095, 12'd4095, 8'd255, 32'h0080_ff40, 32'hff80_00c0);
        push_pixel(12'd4095, 12'd0, 8'd60, 32'hffff_ffff, 32'h0000_0000);
        push_pixel(12'd0, 12'd4095, 8'd60, 32'h0000_0000, 32'hffff_ffff);

        // Zero width rejects every pixel
        set_frame(0, 4096, STD_BT709);
        push_pixel(12'd0, 12'd0, 8'd90, 32'h5555_aaaa, 32'haaaa_5555);
        push_pixel(12'd5, 12'd5, 8'd90, 32'h5555_aaaa, 32'haaaa_5555);

        // One by one frame: only the origin passes
        set_frame(1, 1, STD_BT601);
        push_pixel(12'd0, 12'd0, 8'd100, 32'h7f7f_7f7f, 32'h8181_8181);
        push_pixel(12'd1, 12'd0, 8'd100, 32'h7f7f_7f7f, 32'h8181_8181);
        push_pixel(12'd0, 12'd1, 8'd100, 32'h7f7f_7f7f, 32'h8181_8181);

        // Smallest legal frame
        set_frame(2, 2, STD_BT709);
        push_pixel(12'd1, 12'd1, 8'd170, 32'h0f1e_2d3c, 32'hc3d2_e1f0);
        push_pixel(12'd2, 12'd1, 8'd170, 32'h0f1e_2d3c, 32'hc3d2_e1f0);

        // Random part: one frame setting per phase
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: set_frame(4096, 4096, STD_BT709);
                1: set_frame(640, 480, STD_BT601);
                2: set_frame(2, 2, STD_BT709);
                3: set_frame($urandom_range(2, 4096), $urandom_range(2, 4096), STD_BT601);
                4: set_frame(4096, 2, STD_BT601);
                5: set_frame(3, 4096, STD_BT709);
                6: set_frame($urandom_range(2, 4096), $urandom_range(2, 4096),
                             logic'($urandom_range(0, 1)));
                default: set_frame(1920, 1080, STD_BT601);
            endcase
            // Run the final phase with no idling on either side
            if (ph == 7)
                idle_on = 1'b0;
            if (ph == 3)
            begin
                // Pause the sender mid-phase until every result is back
                push_random(60);
                wait_idle();
                push_random(65);
            end
            else
            begin
                push_random(125);
            end
            // Block the output for a long stretch while pixels keep coming
            if (ph == 0)
                hold_req = 1'b1;
        end

        // Drain, with a bound, then allow for dropped pixels still in flight
        for (int n = 0; n < 20000 && (pixel_q.size() != 0 || in_valid ||
                                      rgb_expect_q.size() != 0); n++)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (rgb_expect_q.size() != 0)
        begin
            $display("%0d expected results never arrived", rgb_expect_q.size());
            fail_cnt += rgb_expect_q.size();
        end
        if (fail_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog far beyond the slowest correct run
    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule
